### rtl/nds_pkg.sv
`timescale 1ns / 1ps

package nds_pkg;

  // default world geometry
  localparam int WORLD_CHUNKS_X_DEF = 8;
  localparam int WORLD_CHUNKS_Y_DEF = 8;
  localparam int WORLD_CHUNKS_Z_DEF = 8;
  localparam int CHUNK_EDGE_DEF     = 16;

  // item field widths
  localparam int BLK_W = 16;
  localparam int PLY_W = 11;
  localparam int ST_W  = 2;
  localparam int CH_W  = 3;
  localparam int CNT_W = 10;

  // request codes
  localparam logic REQ_EDIT = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // result status codes
  localparam logic [ST_W-1:0] ST_EDIT_OK  = 2'd0;
  localparam logic [ST_W-1:0] ST_EDIT_OUT = 2'd1;
  localparam logic [ST_W-1:0] ST_POPPED   = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd3;

endpackage

### rtl/nearest_dirty_chunk_scheduler.sv
`timescale 1ns / 1ps

// Dirty chunk scheduler. Raise start with an item while busy is low; the item is
// taken at that edge. For an in-world edit or a non-empty pop, busy stays high
// until the result is shown. Each result appears for exactly one cycle with done_o
// high and cannot be held off, so the receiver must take it then. After reset the
// block first clears its in-list flag memory, one entry per cycle over
// 2^(bits(X)+bits(Y)+bits(Z)) entries (512 at the default 8x8x8 world), and stays
// busy meanwhile. An edit outside the world is answered from the idle state; an
// edit inside does one flag read for each of the seven candidate chunks plus one
// list append step for each candidate that borders the edited block and lies in
// the world (at most four). A pop scans the pending list through a single memory
// read port, one entry per cycle, into a squared-distance and compare pipeline; a
// pop on an empty list is answered from the idle state.
module nearest_dirty_chunk_scheduler #(
  parameter int WORLD_CHUNKS_X = nds_pkg::WORLD_CHUNKS_X_DEF,
  parameter int WORLD_CHUNKS_Y = nds_pkg::WORLD_CHUNKS_Y_DEF,
  parameter int WORLD_CHUNKS_Z = nds_pkg::WORLD_CHUNKS_Z_DEF,
  parameter int CHUNK_EDGE     = nds_pkg::CHUNK_EDGE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             req_type_i,
  input  logic signed [nds_pkg::BLK_W-1:0] block_x_i,
  input  logic signed [nds_pkg::BLK_W-1:0] block_y_i,
  input  logic signed [nds_pkg::BLK_W-1:0] block_z_i,
  input  logic signed [nds_pkg::PLY_W-1:0] player_x_i,
  input  logic signed [nds_pkg::PLY_W-1:0] player_y_i,
  input  logic signed [nds_pkg::PLY_W-1:0] player_z_i,
  output logic                             done_o,
  output logic [nds_pkg::ST_W-1:0]         status_o,
  output logic [nds_pkg::CH_W-1:0]         chunk_x_o,
  output logic [nds_pkg::CH_W-1:0]         chunk_y_o,
  output logic [nds_pkg::CH_W-1:0]         chunk_z_o,
  output logic [nds_pkg::CNT_W-1:0]        pending_count_o
);
  import nds_pkg::*;

  localparam int XW     = (WORLD_CHUNKS_X > 1) ? $clog2(WORLD_CHUNKS_X) : 1;
  localparam int YW     = (WORLD_CHUNKS_Y > 1) ? $clog2(WORLD_CHUNKS_Y) : 1;
  localparam int ZW     = (WORLD_CHUNKS_Z > 1) ? $clog2(WORLD_CHUNKS_Z) : 1;
  localparam int EW     = XW + YW + ZW;
  localparam int FDEPTH = 2 ** EW;
  localparam int VOLUME = WORLD_CHUNKS_X * WORLD_CHUNKS_Y * WORLD_CHUNKS_Z;
  localparam int LW     = (VOLUME > 1) ? $clog2(VOLUME) : 1;
  localparam int TW     = $clog2(VOLUME + 1);
  localparam int SH     = $clog2(CHUNK_EDGE);
  localparam int CMW    = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);
  localparam int DXW    = ((CMW > PLY_W) ? CMW : PLY_W) + 1;
  localparam int SQW    = 2 * DXW;
  localparam int DW     = SQW + 2;

  localparam logic [XW-1:0] XMAX = XW'(WORLD_CHUNKS_X - 1);
  localparam logic [YW-1:0] YMAX = YW'(WORLD_CHUNKS_Y - 1);
  localparam logic [ZW-1:0] ZMAX = ZW'(WORLD_CHUNKS_Z - 1);
  localparam logic [SH-1:0] OFS_HI = SH'(CHUNK_EDGE - 1);

  localparam logic [2:0] CAND_SELF = 3'd0;
  localparam logic [2:0] CAND_PX   = 3'd1;
  localparam logic [2:0] CAND_PY   = 3'd2;
  localparam logic [2:0] CAND_PZ   = 3'd3;
  localparam logic [2:0] CAND_NX   = 3'd4;
  localparam logic [2:0] CAND_NY   = 3'd5;
  localparam logic [2:0] CAND_NZ   = 3'd6;

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_EDIT_RD  = 3'd2;
  localparam logic [2:0] S_EDIT_WR  = 3'd3;
  localparam logic [2:0] S_SCAN     = 3'd4;
  localparam logic [2:0] S_POP_LAST = 3'd5;
  localparam logic [2:0] S_POP_MOVE = 3'd6;

  // memories
  logic [EW-1:0] list_mem [VOLUME];
  logic          flag_mem [FDEPTH];

  logic [2:0]    state_q, state_d;
  logic [TW-1:0] total_q, total_d;
  logic [EW-1:0] clr_addr_q, clr_addr_d;

  logic [XW-1:0] qx_q, qx_d;
  logic [YW-1:0] qy_q, qy_d;
  logic [ZW-1:0] qz_q, qz_d;
  logic [2:0]    hi_q, hi_d, lo_q, lo_d;
  logic [2:0]    cand_q, cand_d;
  logic [EW-1:0] cand_addr_q, cand_addr_d;

  logic signed [PLY_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;

  logic [TW-1:0] scan_addr_q, scan_addr_d;
  logic          rd_vld_q, rd_vld_d;
  logic [LW-1:0] rd_idx_q, rd_idx_d;
  logic [EW-1:0] list_rd_q;
  logic          flag_rd_q;
  logic          sq_vld_q;
  logic [LW-1:0] sq_idx_q;
  logic [EW-1:0] sq_ent_q;
  logic [SQW-1:0] sqx_q, sqy_q, sqz_q;
  logic [SQW-1:0] sqx_d, sqy_d, sqz_d;
  logic [DW-1:0] best_d_q, best_d_d;
  logic [LW-1:0] best_i_q, best_i_d;
  logic [EW-1:0] best_ent_q, best_ent_d;

  logic             done_q, done_d;
  logic [ST_W-1:0]  status_q, status_d;
  logic [CH_W-1:0]  cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // memory port controls
  logic          lst_we;
  logic [LW-1:0] lst_waddr;
  logic [EW-1:0] lst_wdata;
  logic [LW-1:0] lst_raddr;
  logic          flg_we;
  logic [EW-1:0] flg_waddr;
  logic          flg_wdata;

  // input decode
  logic signed [BLK_W-1:0] bqx, bqy, bqz;
  logic                    in_world;
  logic [TW-1:0]           total_m1;

  // candidate chunk
  logic          cand_ok;
  logic [XW-1:0] ccx;
  logic [YW-1:0] ccy;
  logic [ZW-1:0] ccz;

  // distance datapath
  logic [XW-1:0] ex;
  logic [YW-1:0] ey;
  logic [ZW-1:0] ez;
  logic signed [DXW-1:0] dx, dy, dz;
  logic signed [SQW-1:0] px2, py2, pz2;
  logic [DW-1:0] dsum;

  assign bqx = block_x_i >>> SH;
  assign bqy = block_y_i >>> SH;
  assign bqz = block_z_i >>> SH;
  assign in_world = (bqx >= 0) && (bqx < $signed(BLK_W'(WORLD_CHUNKS_X))) &&
                    (bqy >= 0) && (bqy < $signed(BLK_W'(WORLD_CHUNKS_Y))) &&
                    (bqz >= 0) && (bqz < $signed(BLK_W'(WORLD_CHUNKS_Z)));
  assign total_m1 = total_q - TW'(1);

  always_comb begin
    cand_ok = 1'b0;
    ccx = qx_q;
    ccy = qy_q;
    ccz = qz_q;
    case (cand_q)
      CAND_SELF: cand_ok = 1'b1;
      CAND_PX: begin
        cand_ok = hi_q[0] && (qx_q != XMAX);
        ccx = qx_q + XW'(1);
      end
      CAND_PY: begin
        cand_ok = hi_q[1] && (qy_q != YMAX);
        ccy = qy_q + YW'(1);
      end
      CAND_PZ: begin
        cand_ok = hi_q[2] && (qz_q != ZMAX);
        ccz = qz_q + ZW'(1);
      end
      CAND_NX: begin
        cand_ok = lo_q[0] && (qx_q != '0);
        ccx = qx_q - XW'(1);
      end
      CAND_NY: begin
        cand_ok = lo_q[1] && (qy_q != '0);
        ccy = qy_q - YW'(1);
      end
      CAND_NZ: begin
        cand_ok = lo_q[2] && (qz_q != '0);
        ccz = qz_q - ZW'(1);
      end
      default: cand_ok = 1'b0;
    endcase
  end

  // squared distance of the entry just read
  assign ex  = list_rd_q[XW-1:0];
  assign ey  = list_rd_q[XW+YW-1:XW];
  assign ez  = list_rd_q[EW-1:XW+YW];
  assign dx  = DXW'(px_q) - DXW'(ex);
  assign dy  = DXW'(py_q) - DXW'(ey);
  assign dz  = DXW'(pz_q) - DXW'(ez);
  assign px2 = SQW'(dx) * SQW'(dx);
  assign py2 = SQW'(dy) * SQW'(dy);
  assign pz2 = SQW'(dz) * SQW'(dz);
  assign sqx_d = px2;
  assign sqy_d = py2;
  assign sqz_d = pz2;
  assign dsum = DW'(sqx_q) + DW'(sqy_q) + DW'(sqz_q);

  assign lst_raddr = (state_q == S_POP_LAST) ? total_m1[LW-1:0] : scan_addr_q[LW-1:0];

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    clr_addr_d  = clr_addr_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    qz_d        = qz_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    cand_d      = cand_q;
    cand_addr_d = cand_addr_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    scan_addr_d = scan_addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    best_d_d    = best_d_q;
    best_i_d    = best_i_q;
    best_ent_d  = best_ent_q;
    done_d      = 1'b0;
    status_d    = status_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    cnt_d       = cnt_q;
    lst_we      = 1'b0;
    lst_waddr   = total_q[LW-1:0];
    lst_wdata   = cand_addr_q;
    flg_we      = 1'b0;
    flg_waddr   = cand_addr_q;
    flg_wdata   = 1'b1;

    // closest-so-far update, lowest index wins on a tie
    if (sq_vld_q && (dsum < best_d_q)) begin
      best_d_d   = dsum;
      best_i_d   = sq_idx_q;
      best_ent_d = sq_ent_q;
    end

    case (state_q)
      S_CLEAR: begin
        flg_we    = 1'b1;
        flg_waddr = clr_addr_q;
        flg_wdata = 1'b0;
        clr_addr_d = clr_addr_q + EW'(1);
        if (clr_addr_q == EW'(FDEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_type_i == REQ_EDIT) begin
            if (in_world) begin
              qx_d   = bqx[XW-1:0];
              qy_d   = bqy[YW-1:0];
              qz_d   = bqz[ZW-1:0];
              hi_d   = {block_z_i[SH-1:0] == OFS_HI, block_y_i[SH-1:0] == OFS_HI,
                        block_x_i[SH-1:0] == OFS_HI};
              lo_d   = {block_z_i[SH-1:0] == '0, block_y_i[SH-1:0] == '0,
                        block_x_i[SH-1:0] == '0};
              cand_d = CAND_SELF;
              state_d = S_EDIT_RD;
            end else begin
              done_d   = 1'b1;
              status_d = ST_EDIT_OUT;
              cx_d     = '0;
              cy_d     = '0;
              cz_d     = '0;
              cnt_d    = CNT_W'(total_q);
            end
          end else if (total_q == '0) begin
            done_d   = 1'b1;
            status_d = ST_EMPTY;
            cx_d     = '0;
            cy_d     = '0;
            cz_d     = '0;
            cnt_d    = '0;
          end else begin
            px_d        = player_x_i;
            py_d        = player_y_i;
            pz_d        = player_z_i;
            scan_addr_d = '0;
            best_d_d    = '1;
            best_i_d    = '0;
            best_ent_d  = '0;
            state_d     = S_SCAN;
          end
        end
      end
      S_EDIT_RD: begin
        if (cand_ok) begin
          cand_addr_d = {ccz, ccy, ccx};
          state_d     = S_EDIT_WR;
        end else if (cand_q == CAND_NZ) begin
          done_d   = 1'b1;
          status_d = ST_EDIT_OK;
          cx_d     = CH_W'(qx_q);
          cy_d     = CH_W'(qy_q);
          cz_d     = CH_W'(qz_q);
          cnt_d    = CNT_W'(total_q);
          state_d  = S_IDLE;
        end else begin
          cand_d = cand_q + 3'd1;
        end
      end
      S_EDIT_WR: begin
        // append only chunks not yet in the list
        if (!flag_rd_q) begin
          lst_we  = 1'b1;
          flg_we  = 1'b1;
          total_d = total_q + TW'(1);
        end
        if (cand_q == CAND_NZ) begin
          done_d   = 1'b1;
          status_d = ST_EDIT_OK;
          cx_d     = CH_W'(qx_q);
          cy_d     = CH_W'(qy_q);
          cz_d     = CH_W'(qz_q);
          cnt_d    = CNT_W'(total_d);
          state_d  = S_IDLE;
        end else begin
          cand_d  = cand_q + 3'd1;
          state_d = S_EDIT_RD;
        end
      end
      S_SCAN: begin
        if (scan_addr_q < total_q) begin
          rd_vld_d    = 1'b1;
          rd_idx_d    = scan_addr_q[LW-1:0];
          scan_addr_d = scan_addr_q + TW'(1);
        end else if (!rd_vld_q && !sq_vld_q) begin
          state_d = S_POP_LAST;
        end
      end
      S_POP_LAST: begin
        state_d = S_POP_MOVE;
      end
      S_POP_MOVE: begin
        // last entry fills the freed slot
        lst_we    = 1'b1;
        lst_waddr = best_i_q;
        lst_wdata = list_rd_q;
        flg_we    = 1'b1;
        flg_waddr = best_ent_q;
        flg_wdata = 1'b0;
        total_d   = total_m1;
        done_d    = 1'b1;
        status_d  = ST_POPPED;
        cx_d      = CH_W'(best_ent_q[XW-1:0]);
        cy_d      = CH_W'(best_ent_q[XW+YW-1:XW]);
        cz_d      = CH_W'(best_ent_q[EW-1:XW+YW]);
        cnt_d     = CNT_W'(total_m1);
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      total_q    <= '0;
      clr_addr_q <= '0;
      cand_q     <= '0;
      rd_vld_q   <= 1'b0;
      sq_vld_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      clr_addr_q <= clr_addr_d;
      cand_q     <= cand_d;
      rd_vld_q   <= rd_vld_d;
      sq_vld_q   <= rd_vld_q;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q        <= qx_d;
    qy_q        <= qy_d;
    qz_q        <= qz_d;
    hi_q        <= hi_d;
    lo_q        <= lo_d;
    cand_addr_q <= cand_addr_d;
    px_q        <= px_d;
    py_q        <= py_d;
    pz_q        <= pz_d;
    scan_addr_q <= scan_addr_d;
    rd_idx_q    <= rd_idx_d;
    sq_idx_q    <= rd_idx_q;
    sq_ent_q    <= list_rd_q;
    sqx_q       <= sqx_d;
    sqy_q       <= sqy_d;
    sqz_q       <= sqz_d;
    best_d_q    <= best_d_d;
    best_i_q    <= best_i_d;
    best_ent_q  <= best_ent_d;
    status_q    <= status_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    cz_q        <= cz_d;
    cnt_q       <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      list_mem[lst_waddr] <= lst_wdata;
    end
    list_rd_q <= list_mem[lst_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (flg_we) begin
      flag_mem[flg_waddr] <= flg_wdata;
    end
    flag_rd_q <= flag_mem[{ccz, ccy, ccx}];
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign chunk_x_o       = cx_q;
  assign chunk_y_o       = cy_q;
  assign chunk_z_o       = cz_q;
  assign pending_count_o = cnt_q;

`ifndef NO_ASSERTIONS
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TW'(VOLUME))
    else $error("pending total beyond world volume");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while still busy");

  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_type_i == REQ_POP && total_q == '0)
    |=> (done_o && status_o == ST_EMPTY && pending_count_o == '0))
    else $error("pop on empty list not answered at once");

  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_MOVE) |=> (total_q == $past(total_q) - TW'(1)))
    else $error("pop did not shrink the list");
`endif

endmodule
